// ----- sv/rpc_pkg.sv -----
// Shared types, register codes and helpers for the RC pulse capture block.
package rpc_pkg;

	// Width of each per-pin configuration mask
	localparam int MASK_W = 24;
	// Bits of a flat pin index (port * pins + pin) at the largest configuration
	localparam int PIN_IDX_W = 6;
	// Pins carried by one sample item
	localparam int PORT_PINS_W = 8;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_ATTACHED  = 2'd1;
	localparam logic [1:0] REG_FREQ_ONLY = 2'd2;

	// Item command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Configuration masks shared by front and back
	typedef struct packed {
		logic [MASK_W-1:0] enable;
		logic [MASK_W-1:0] attached;
		logic [MASK_W-1:0] freq_only;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic                   cmd;
		logic [1:0]             port_id;
		logic [PORT_PINS_W-1:0] pend;
		logic [PORT_PINS_W-1:0] levels;
		logic [31:0]            time_us;
		logic [4:0]             channel;
	} item_t;

	// Look up one pin's bit in a mask; pins past the mask read as clear
	function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
			input logic [PIN_IDX_W-1:0] idx);
		logic res;
		res = 1'b0;
		if (idx < PIN_IDX_W'(MASK_W)) begin
			res = mask[idx[4:0]];
		end
		return res;
	endfunction

endpackage

// ----- sv/rpc_front.sv -----
// Front end: accepts items, tracks port levels and finds the enabled pins that changed.
module rpc_front #(
	parameter int NUM_PORTS     = 3,
	parameter int PINS_PER_PORT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rpc_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [1:0]                     port_id,
	input  logic [rpc_pkg::PORT_PINS_W-1:0] pin_levels,
	input  logic [31:0]                    time_us,
	input  logic [4:0]                     channel,
	input  logic                           q_full,
	output logic                           q_push,
	output rpc_pkg::item_t                 q_data
);

	localparam int PORT_IW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [rpc_pkg::PORT_PINS_W-1:0] prev_q [NUM_PORTS];
	logic [rpc_pkg::PORT_PINS_W-1:0] prev_sel;
	logic [rpc_pkg::PORT_PINS_W-1:0] en_bits;
	logic                            port_ok;
	logic                            accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;
	assign port_ok  = 32'(port_id) < NUM_PORTS;
	assign prev_sel = port_ok ? prev_q[PORT_IW'(port_id)] : '0;

	// Gather enable bits for the pins of the addressed port
	always_comb begin
		en_bits = '0;
		for (int p = 0; p < rpc_pkg::PORT_PINS_W; p++) begin
			if (p < PINS_PER_PORT && port_ok) begin
				en_bits[p] = rpc_pkg::mask_bit(cfg.enable,
					rpc_pkg::PIN_IDX_W'(int'(port_id) * PINS_PER_PORT + p));
			end
		end
	end

	// Build the queue entry
	always_comb begin
		q_data         = '0;
		q_data.cmd     = cmd;
		q_data.port_id = port_id;
		q_data.levels  = pin_levels;
		q_data.time_us = time_us;
		q_data.channel = channel;
		if (cmd == rpc_pkg::CMD_SAMPLE && port_ok) begin
			q_data.pend = (pin_levels ^ prev_sel) & en_bits;
		end
	end

	// Hold the last levels seen on each port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (accept && cmd == rpc_pkg::CMD_SAMPLE && port_ok) begin
			prev_q[PORT_IW'(port_id)] <= pin_levels;
		end
	end

endmodule

// ----- sv/rpc_fifo.sv -----
// Two-entry queue between the front and back ends.
module rpc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpc_pkg::item_t wr_data,
	output logic           full,
	input  logic           pop,
	output rpc_pkg::item_t rd_data,
	output logic           empty
);

	rpc_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- sv/rpc_back.sv -----
// Back end: walks changed pins one per cycle (pausing to add each measured width), keeps channel records, serves reads.
module rpc_back #(
	parameter int NUM_PORTS     = 3,
	parameter int PINS_PER_PORT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rpc_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  rpc_pkg::item_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    last_width,
	output logic [31:0]    width_sum,
	output logic [15:0]    pulse_count,
	output logic           valid_res,
	output logic           alive,
	output logic           warn
);

	localparam int NUM_PINS = NUM_PORTS * PINS_PER_PORT;
	localparam int IDX_W    = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                      state_q;
	rpc_pkg::item_t                  cur_q;
	logic [rpc_pkg::PORT_PINS_W-1:0] pend_q;
	logic [IDX_W-1:0]                idx_q;
	logic [31:0]                     w_q;
	logic                            warn_q;
	logic                            out_valid_q;

	logic [31:0] start_q [NUM_PINS];
	logic [31:0] lat_q   [NUM_PINS];
	logic [31:0] acc_q   [NUM_PINS];
	logic [15:0] cnt_q   [NUM_PINS];
	logic        alive_q [NUM_PINS];

	logic [2:0]                    pin_sel;
	logic [IDX_W-1:0]              pin_idx;
	logic [rpc_pkg::PIN_IDX_W-1:0] pin_idx_w;
	logic                          pin_high;
	logic [IDX_W-1:0]              rd_idx;
	logic                          chan_ok;
	logic                          is_read;
	logic                          out_free;
	logic                          load_out;
	logic [32:0]                   sum_full;

	// Pick the highest pending pin
	always_comb begin
		pin_sel = '0;
		for (int i = 0; i < rpc_pkg::PORT_PINS_W; i++) begin
			if (pend_q[i]) begin
				pin_sel = 3'(i);
			end
		end
	end

	assign pin_idx   = IDX_W'(int'(cur_q.port_id) * PINS_PER_PORT + int'(pin_sel));
	assign pin_idx_w = rpc_pkg::PIN_IDX_W'(pin_idx);
	assign pin_high  = cur_q.levels[pin_sel];
	assign rd_idx    = IDX_W'(cur_q.channel);
	assign chan_ok   = 32'(cur_q.channel) < NUM_PINS;
	assign is_read   = cur_q.cmd == rpc_pkg::CMD_READ && chan_ok;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = state_q == ST_DONE && out_free;
	assign q_pop     = state_q == ST_IDLE && !q_empty;
	assign sum_full  = {1'b0, acc_q[idx_q]} + {1'b0, w_q};
	assign out_valid = out_valid_q;

	// Payload registers: current item, measured width, result fields
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (state_q == ST_SCAN) begin
			w_q   <= cur_q.time_us - start_q[pin_idx];
			idx_q <= pin_idx;
		end
		if (load_out) begin
			last_width  <= is_read ? lat_q[rd_idx] : '0;
			width_sum   <= is_read ? acc_q[rd_idx] : '0;
			pulse_count <= is_read ? cnt_q[rd_idx] : '0;
			valid_res   <= is_read ? (cnt_q[rd_idx] != '0) : 1'b0;
			alive       <= is_read ? alive_q[rd_idx] : 1'b0;
			warn        <= warn_q;
		end
	end

	// Sequencer and channel records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			warn_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PINS; i++) begin
				start_q[i] <= '0;
				lat_q[i]   <= '0;
				acc_q[i]   <= '0;
				cnt_q[i]   <= '0;
				alive_q[i] <= 1'b0;
			end
		end else begin
			// Raise the result on load, drop it once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						pend_q  <= q_data.pend;
						state_q <= (q_data.cmd == rpc_pkg::CMD_READ) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pend_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						pend_q[pin_sel] <= 1'b0;
						if (!rpc_pkg::mask_bit(cfg.attached, pin_idx_w)) begin
							warn_q <= 1'b1;
						end else if (rpc_pkg::mask_bit(cfg.freq_only, pin_idx_w)) begin
							if (pin_high && cnt_q[pin_idx] != '1) begin
								cnt_q[pin_idx] <= cnt_q[pin_idx] + 16'd1;
							end
						end else if (pin_high) begin
							start_q[pin_idx] <= cur_q.time_us;
						end else if (start_q[pin_idx] != '0) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					// Fold the measured width into the record
					acc_q[idx_q]   <= sum_full[32] ? '1 : sum_full[31:0];
					lat_q[idx_q]   <= w_q;
					alive_q[idx_q] <= 1'b1;
					if (cnt_q[idx_q] != '1) begin
						cnt_q[idx_q] <= cnt_q[idx_q] + 16'd1;
					end
					state_q <= ST_SCAN;
				end
				ST_DONE: begin
					if (out_free) begin
						if (is_read) begin
							acc_q[rd_idx] <= '0;
							cnt_q[rd_idx] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/rc_pwm_pulse_capture.sv -----
// Top level of the RC pulse capture block: register port, front end, queue, back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | cmd, port_id, pin_levels, time_us, channel
//  output   | out_valid/ out_stall | last_width, width_sum, pulse_count, valid_res,
//           |                      | alive, warn
//  config   | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// A read item passes the back end's idle and done states; a sample item passes idle,
// a scan step per enabled pin that changed, a final scan, an accumulate step per pulse
// measured, then done. The back end handles one pin per cycle, pausing to accumulate
// each width and waiting in done while the output is stalled. A two-entry queue lets
// the front keep taking items meanwhile. Reset clears all channel records, levels and
// masks. A stalled output holds its result while the back end may finish the next item.
module rc_pwm_pulse_capture #(
	parameter int NUM_PORTS     = 3,
	parameter int PINS_PER_PORT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [1:0]  port_id,
	input  logic [7:0]  pin_levels,
	input  logic [31:0] time_us,
	input  logic [4:0]  channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] last_width,
	output logic [31:0] width_sum,
	output logic [15:0] pulse_count,
	output logic        valid_res,
	output logic        alive,
	output logic        warn
);

	rpc_pkg::cfg_t  cfg_q;
	rpc_pkg::item_t push_data;
	rpc_pkg::item_t pop_data;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				rpc_pkg::REG_ENABLE:    cfg_q.enable    <= pwdata[rpc_pkg::MASK_W-1:0];
				rpc_pkg::REG_ATTACHED:  cfg_q.attached  <= pwdata[rpc_pkg::MASK_W-1:0];
				rpc_pkg::REG_FREQ_ONLY: cfg_q.freq_only <= pwdata[rpc_pkg::MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			rpc_pkg::REG_ENABLE:    prdata = 32'(cfg_q.enable);
			rpc_pkg::REG_ATTACHED:  prdata = 32'(cfg_q.attached);
			rpc_pkg::REG_FREQ_ONLY: prdata = 32'(cfg_q.freq_only);
			default:                prdata = '0;
		endcase
	end

	rpc_front #(
		.NUM_PORTS     (NUM_PORTS),
		.PINS_PER_PORT (PINS_PER_PORT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.port_id    (port_id),
		.pin_levels (pin_levels),
		.time_us    (time_us),
		.channel    (channel),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (push_data)
	);

	rpc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (push_data),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (pop_data),
		.empty   (q_empty)
	);

	rpc_back #(
		.NUM_PORTS     (NUM_PORTS),
		.PINS_PER_PORT (PINS_PER_PORT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.last_width  (last_width),
		.width_sum   (width_sum),
		.pulse_count (pulse_count),
		.valid_res   (valid_res),
		.alive       (alive),
		.warn        (warn)
	);

endmodule
